### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define PMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define PMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// Types and constants of the power mode sequencer.
// ----------------------------------------------------------------------------
package pms_pkg;

    typedef enum logic [1:0] {
        MODE_ACTIVE  = 2'd0,
        MODE_PENDING = 2'd1,
        MODE_SLEEP   = 2'd2,
        MODE_HMI     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BTN_NONE = 2'd0,
        BTN_ZERO = 2'd1,
        BTN_ONE  = 2'd2
    } t_button;

    typedef enum logic [1:0] {
        CFG_SHUTDOWN_TIMEOUT = 2'd0,
        CFG_SLEEP_POLL       = 2'd1,
        CFG_HMI_TIMEOUT      = 2'd2
    } t_cfg_reg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned WAIT_W     = 16;

    localparam logic [CFG_DATA_W-1:0] SHUTDOWN_TIMEOUT_RST = 16'd5000;
    localparam logic [CFG_DATA_W-1:0] SLEEP_POLL_RST       = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] HMI_TIMEOUT_RST      = 16'd60000;

    typedef struct packed {
        logic action;
        logic ev_shutdown_request;
        logic ev_shutdown_abort;
        logic ev_alarm_wakeup;
        logic ev_button_zero;
        logic ev_button_one;
    } t_in_item;

    typedef struct packed {
        t_mode   mode;
        logic    host_power_on;
        logic    rail5v_on;
        t_button button_report;
        logic    entered;
    } t_result;

endpackage

### hdl/pms_if.sv
// ----------------------------------------------------------------------------
// pms_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface pms_in_if;
    logic              valid;
    logic              ready;
    pms_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pms_out_if;
    logic             valid;
    logic             ready;
    pms_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/power_mode_sequencer.sv
// ----------------------------------------------------------------------------
// power_mode_sequencer
// Four-mode power controller driven by ms ticks and event masks.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake       | word
//  i_item    | in  | valid/ready     | action + five event flags
//  o_result  | out | valid/ready     | mode, supply enables, button, entered
//  i_cfg_*   | in  | write enable    | register index + 16-bit timeout value
//
//  One word per cycle: the next mode, wait count and result are computed
//  in the accept cycle and land in their registers on the same edge.
//  Result is visible in the cycle after accept; input stays ready while the
//  result register is empty or being taken this cycle.
//  Synchronous active-low reset: mode active, supplies on, timeouts at
//  their defaults, no result pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module power_mode_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    pms_in_if.sink                               i_item,
    pms_out_if.source                            o_result,
    input  logic                                 i_cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [pms_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [pms_pkg::CFG_DATA_W-1:0] r_shutdown_timeout;
    logic [pms_pkg::CFG_DATA_W-1:0] r_sleep_poll;
    logic [pms_pkg::CFG_DATA_W-1:0] r_hmi_timeout;

    pms_pkg::t_mode             r_mode, n_mode;
    logic [pms_pkg::WAIT_W-1:0] r_wait, n_wait;
    logic                       r_host, n_host;
    logic                       r_rail, n_rail;

    pms_pkg::t_result           r_res, n_res;
    logic                       r_out_valid;

    logic                       accept;
    logic [pms_pkg::WAIT_W-1:0] wait_inc;
    logic [pms_pkg::WAIT_W-1:0] limit;
    logic                       do_enter;
    pms_pkg::t_mode             target;
    pms_pkg::t_button           report;

    assign i_item.ready   = !r_out_valid || o_result.ready;
    assign accept         = i_item.valid && i_item.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shutdown_timeout <= pms_pkg::SHUTDOWN_TIMEOUT_RST;
            r_sleep_poll       <= pms_pkg::SLEEP_POLL_RST;
            r_hmi_timeout      <= pms_pkg::HMI_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pms_pkg::CFG_SHUTDOWN_TIMEOUT: r_shutdown_timeout <= i_cfg_data;
                pms_pkg::CFG_SLEEP_POLL:       r_sleep_poll       <= i_cfg_data;
                pms_pkg::CFG_HMI_TIMEOUT:      r_hmi_timeout      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mode register and supply state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pms_pkg::MODE_ACTIVE;
            r_wait <= '0;
            r_host <= 1'b1;
            r_rail <= 1'b1;
        end else begin
            r_mode <= n_mode;
            r_wait <= n_wait;
            r_host <= n_host;
            r_rail <= n_rail;
        end
    end

    // Saturating tick count and per-mode timeout
    assign wait_inc = (r_wait == '1) ? r_wait : r_wait + 1'b1;

    always_comb begin
        unique case (r_mode)
            pms_pkg::MODE_PENDING: limit = r_shutdown_timeout;
            pms_pkg::MODE_SLEEP:   limit = r_sleep_poll;
            pms_pkg::MODE_HMI:     limit = r_hmi_timeout;
            default:               limit = '1;
        endcase
    end

    always_comb begin
        do_enter = 1'b0;
        target   = r_mode;
        report   = pms_pkg::BTN_NONE;
        n_mode   = r_mode;
        n_wait   = r_wait;
        n_host   = r_host;
        n_rail   = r_rail;

        if (accept) begin
            if (!i_item.data.action) begin
                n_wait = wait_inc;
                if (r_mode != pms_pkg::MODE_ACTIVE && wait_inc >= limit) begin
                    do_enter = 1'b1;
                    target   = pms_pkg::MODE_SLEEP;
                end
            end else begin
                do_enter = 1'b1;
                unique case (r_mode)
                    pms_pkg::MODE_ACTIVE: begin
                        target = i_item.data.ev_shutdown_request ?
                                 pms_pkg::MODE_PENDING : pms_pkg::MODE_ACTIVE;
                    end
                    pms_pkg::MODE_PENDING: begin
                        target = (i_item.data.ev_shutdown_abort ||
                                  i_item.data.ev_alarm_wakeup) ?
                                 pms_pkg::MODE_ACTIVE : pms_pkg::MODE_SLEEP;
                    end
                    pms_pkg::MODE_SLEEP: begin
                        priority if (i_item.data.ev_alarm_wakeup) begin
                            target = pms_pkg::MODE_ACTIVE;
                        end else if (i_item.data.ev_button_zero ||
                                     i_item.data.ev_button_one) begin
                            target = pms_pkg::MODE_HMI;
                        end else begin
                            target = pms_pkg::MODE_SLEEP;
                        end
                    end
                    default: begin
                        if (i_item.data.ev_alarm_wakeup) begin
                            target = pms_pkg::MODE_ACTIVE;
                        end else begin
                            target = pms_pkg::MODE_SLEEP;
                            priority if (i_item.data.ev_button_zero) begin
                                report = pms_pkg::BTN_ZERO;
                            end else if (i_item.data.ev_button_one) begin
                                report = pms_pkg::BTN_ONE;
                            end else begin
                                report = pms_pkg::BTN_NONE;
                            end
                        end
                    end
                endcase
            end
        end

        // Every entry restarts the count; actions only on a real change
        if (do_enter) begin
            n_wait = '0;
            if (target != r_mode) begin
                if (r_mode == pms_pkg::MODE_SLEEP) begin
                    n_rail = 1'b1;
                end
                if (target == pms_pkg::MODE_SLEEP) begin
                    n_host = 1'b0;
                    n_rail = 1'b0;
                end else if (target == pms_pkg::MODE_ACTIVE) begin
                    n_host = 1'b1;
                end
                n_mode = target;
            end
        end

        n_res.mode          = n_mode;
        n_res.host_power_on = n_host;
        n_res.rail5v_on     = n_rail;
        n_res.button_report = report;
        n_res.entered       = do_enter;
    end

    // Result register: load on accept, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    `PMS_ASSERT(a_sleep_supplies_off, i_clk, i_rst_n, (r_mode == pms_pkg::MODE_SLEEP) |-> (!r_host && !r_rail), "deep sleep with a supply enabled")
    `PMS_ASSERT(a_active_host_on, i_clk, i_rst_n, (r_mode == pms_pkg::MODE_ACTIVE) |-> r_host, "active mode with host supply off")
    `PMS_ASSERT(a_event_restarts, i_clk, i_rst_n, (accept && i_item.data.action) |=> (r_wait == '0 && r_res.entered && r_out_valid), "event did not restart the wait count")
    `PMS_ASSERT_ALWAYS(a_report_only_hmi, i_clk, (accept && i_item.data.action && r_mode != pms_pkg::MODE_HMI) |=> (r_res.button_report == pms_pkg::BTN_NONE), "button reported outside interface mode")

endmodule
